/* design/ulf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_pkg
// Shared types, constants and the code point folding function.
// ----------------------------------------------------------------------------
package ulf_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] n;
    logic [6:0] c1;
    logic [6:0] c2;
  } fold_t;

  // one folded code point waiting for the back end
  typedef struct packed {
    logic       two;
    logic [6:0] c1;
    logic [6:0] c2;
  } q_ent_t;

  typedef struct packed {
    logic   push;
    q_ent_t ent;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    q_ent_t ent;
  } q_rd_t;

  localparam fold_t FOLD_EMPTY = '{n: 2'd0, c1: 7'd0, c2: 7'd0};

  function automatic fold_t mk1(input logic [7:0] c);
    fold_t f;
    f.n  = 2'd1;
    f.c1 = c[6:0];
    f.c2 = 7'd0;
    return f;
  endfunction

  function automatic fold_t mk2(input logic [7:0] a, input logic [7:0] b);
    fold_t f;
    f.n  = 2'd2;
    f.c1 = a[6:0];
    f.c2 = b[6:0];
    return f;
  endfunction

  // Folds a code point to zero, one or two lower-case ASCII characters.
  // The Latin range is a sorted chain on upper bounds; the multiplication
  // and division signs fall in the gaps.
  function automatic fold_t fold_code(input logic [20:0] cp);
    fold_t      f;
    logic [8:0] v;
    f = FOLD_EMPTY;
    v = cp[8:0];
    if (cp < 21'h80) begin
      if (cp >= 21'h30 && cp <= 21'h39)      f = mk1({1'b0, cp[6:0]});
      else if (cp >= 21'h61 && cp <= 21'h7A) f = mk1({1'b0, cp[6:0]});
      else if (cp >= 21'h41 && cp <= 21'h5A) f = mk1({1'b0, cp[6:0] + 7'd32});
    end else if (cp[20:9] == 12'd0 && v >= 9'h0C0 && v <= 9'h17F) begin
      if      (v <= 9'h0C5) f = mk1("a");
      else if (v <= 9'h0C6) f = mk2("a", "e");
      else if (v <= 9'h0C7) f = mk1("c");
      else if (v <= 9'h0CB) f = mk1("e");
      else if (v <= 9'h0CF) f = mk1("i");
      else if (v <= 9'h0D0) f = mk1("d");
      else if (v <= 9'h0D1) f = mk1("n");
      else if (v <= 9'h0D6) f = mk1("o");
      else if (v <= 9'h0D7) f = FOLD_EMPTY;
      else if (v <= 9'h0D8) f = mk1("o");
      else if (v <= 9'h0DC) f = mk1("u");
      else if (v <= 9'h0DD) f = mk1("y");
      else if (v <= 9'h0DE) f = mk2("t", "h");
      else if (v <= 9'h0DF) f = mk2("s", "s");
      else if (v <= 9'h0E5) f = mk1("a");
      else if (v <= 9'h0E6) f = mk2("a", "e");
      else if (v <= 9'h0E7) f = mk1("c");
      else if (v <= 9'h0EB) f = mk1("e");
      else if (v <= 9'h0EF) f = mk1("i");
      else if (v <= 9'h0F0) f = mk1("d");
      else if (v <= 9'h0F1) f = mk1("n");
      else if (v <= 9'h0F6) f = mk1("o");
      else if (v <= 9'h0F7) f = FOLD_EMPTY;
      else if (v <= 9'h0F8) f = mk1("o");
      else if (v <= 9'h0FC) f = mk1("u");
      else if (v <= 9'h0FD) f = mk1("y");
      else if (v <= 9'h0FE) f = mk2("t", "h");
      else if (v <= 9'h0FF) f = mk1("y");
      else if (v <= 9'h105) f = mk1("a");
      else if (v <= 9'h10D) f = mk1("c");
      else if (v <= 9'h111) f = mk1("d");
      else if (v <= 9'h11B) f = mk1("e");
      else if (v <= 9'h123) f = mk1("g");
      else if (v <= 9'h127) f = mk1("h");
      else if (v <= 9'h131) f = mk1("i");
      else if (v <= 9'h133) f = mk2("i", "j");
      else if (v <= 9'h135) f = mk1("j");
      else if (v <= 9'h138) f = mk1("k");
      else if (v <= 9'h142) f = mk1("l");
      else if (v <= 9'h14B) f = mk1("n");
      else if (v <= 9'h151) f = mk1("o");
      else if (v <= 9'h153) f = mk2("o", "e");
      else if (v <= 9'h159) f = mk1("r");
      else if (v <= 9'h161) f = mk1("s");
      else if (v <= 9'h167) f = mk1("t");
      else if (v <= 9'h173) f = mk1("u");
      else if (v <= 9'h175) f = mk1("w");
      else if (v <= 9'h178) f = mk1("y");
      else if (v <= 9'h17E) f = mk1("z");
      else                  f = mk1("s");
    end
    return f;
  endfunction

endpackage

/* design/ulf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_if
// Valid/ready channels for raw bytes in and folded characters out.
// ----------------------------------------------------------------------------
interface ulf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ulf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

/* design/ulf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_front
// UTF-8 decoder: one byte per cycle unless q_full; pushes folded code points.
// ----------------------------------------------------------------------------
module ulf_front (
  input  logic             clk,
  input  logic             rst,
  ulf_in_if.sink           byte_in,
  input  logic             q_full,
  output ulf_pkg::q_wr_t   q_wr
);
  import ulf_pkg::*;

  logic [20:0] pending_code;
  logic [20:0] pending_code_next;
  logic [1:0]  bytes_left;
  logic [1:0]  bytes_left_next;
  logic [20:0] joined;
  logic [20:0] cp;
  logic        done;
  logic        accept;
  logic [7:0]  b;
  fold_t       fold;

  assign b              = byte_in.data_byte;
  assign byte_in.ready  = !q_full;
  assign accept         = byte_in.valid && !q_full;
  assign joined         = {pending_code[14:0], b[5:0]};

  always_comb begin
    pending_code_next = pending_code;
    bytes_left_next   = bytes_left;
    done              = 1'b0;
    cp                = 21'd0;
    if (b[7:6] == 2'b10) begin
      // continuation; stray ones are skipped
      if (bytes_left != 2'd0) begin
        bytes_left_next = bytes_left - 2'd1;
        if (bytes_left == 2'd1) begin
          done              = 1'b1;
          cp                = joined;
          pending_code_next = 21'd0;
        end else begin
          pending_code_next = joined;
        end
      end
    end else begin
      pending_code_next = 21'd0;
      bytes_left_next   = 2'd0;
      if (!b[7]) begin
        done = 1'b1;
        cp   = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        pending_code_next = {16'd0, b[4:0]};
        bytes_left_next   = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        pending_code_next = {17'd0, b[3:0]};
        bytes_left_next   = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        pending_code_next = {18'd0, b[2:0]};
        bytes_left_next   = 2'd3;
      end
    end
    if (byte_in.end_of_string) begin
      pending_code_next = 21'd0;
      bytes_left_next   = 2'd0;
    end
  end

  assign fold        = fold_code(cp);
  assign q_wr.push   = accept && done && (fold.n != 2'd0);
  assign q_wr.ent.two = (fold.n == 2'd2);
  assign q_wr.ent.c1 = fold.c1;
  assign q_wr.ent.c2 = fold.c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_code <= 21'd0;
      bytes_left   <= 2'd0;
    end else if (accept) begin
      pending_code <= pending_code_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

/* design/ulf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_queue
// Short FIFO of folded code points between decoder and output stage.
// ----------------------------------------------------------------------------
module ulf_queue (
  input  logic             clk,
  input  logic             rst,
  input  ulf_pkg::q_wr_t   q_wr,
  input  logic             pop,
  output logic             q_full,
  output ulf_pkg::q_rd_t   q_rd
);
  import ulf_pkg::*;

  q_ent_t           mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign q_full     = (count == QCW'(QDEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.ent   = mem[rd_ptr];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_wr.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QAW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QAW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/ulf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_back
// Output stage: emits one or two characters per queued code point.
// ----------------------------------------------------------------------------
module ulf_back (
  input  logic             clk,
  input  logic             rst,
  input  ulf_pkg::q_rd_t   q_rd,
  output logic             pop,
  ulf_out_if.source        char_out
);
  import ulf_pkg::*;

  logic       out_valid;
  logic [6:0] out_char;
  logic       run_last;
  logic       phase;   // second letter of a two-letter entry is next
  logic       load;

  assign load  = !out_valid || char_out.ready;
  assign pop   = load && q_rd.valid && (phase || !q_rd.ent.two);

  assign char_out.valid    = out_valid;
  assign char_out.out_char = out_char;
  assign char_out.run_last = run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= q_rd.valid;
      if (q_rd.valid) begin
        phase <= !phase && q_rd.ent.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_rd.valid) begin
      if (phase) begin
        out_char <= q_rd.ent.c2;
        run_last <= 1'b1;
      end else begin
        out_char <= q_rd.ent.c1;
        run_last <= !q_rd.ent.two;
      end
    end
  end

endmodule

/* design/utf8_latin_fold_normalizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin_fold_normalizer
// UTF-8 byte stream to lower-case ASCII letters and digits.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in  : one UTF-8 byte per request, end_of_string set on the last
//              byte of a string. A partial sequence left after it is lost.
//   char_out : folded characters, '0'-'9' or 'a'-'z'. run_last marks the
//              final character produced by one input byte.
// Throughput: one byte per cycle. A code point that folds to two letters
//   is emitted as two characters; the four-entry queue between decoder and
//   output stage absorbs these, so the byte side stalls only when the
//   queue fills (output port bandwidth of one character per ready cycle).
// Path: a character reaches char_out after the byte that completes its code
//   point is accepted, through the queue write and then the output register.
// Bytes that complete nothing (leads, stray continuations, dropped code
//   points) produce no request on char_out.
// Reset: synchronous; clears the decoder state, the queue and the output
//   register. Ready on byte_in is high once reset has cleared the queue.
// Stall: while char_out is held off, the output register keeps its request
//   and the queue fills; byte_in.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module utf8_latin_fold_normalizer (
  input  logic       clk,
  input  logic       rst,
  ulf_in_if.sink     byte_in,
  ulf_out_if.source  char_out
);
  import ulf_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  // decoder and folder
  ulf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  // decoupling queue
  ulf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_full (q_full),
    .q_rd   (q_rd)
  );

  // character emitter
  ulf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rd     (q_rd),
    .pop      (pop),
    .char_out (char_out)
  );

  // decoder never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_full)
    else $error("push into full queue");

  // first letter of a pair is followed at once by its closing letter
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (char_out.valid && char_out.ready && !char_out.run_last)
      |=> (char_out.valid && char_out.run_last))
    else $error("second letter of pair missing");

  // queued work reaches an empty output register next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (q_rd.valid && !char_out.valid) |=> char_out.valid)
    else $error("output stage failed to load");

endmodule
